### design/wfrm_pkg.sv
package wfrm_pkg;

    // Ring depth and the derived widths.
    localparam int WINDOW      = 32;
    localparam int HALF_WINDOW = WINDOW / 2;
    localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SEEN_W      = $clog2(HALF_WINDOW + 2);

    localparam int STAMP_W = 32;
    localparam int SUM_W   = STAMP_W + SLOT_W;
    localparam int RATE_W  = 14;

    localparam int RATE_SCALE = 1000;
    localparam int RATE_MAX   = 9999;
    localparam int NUMERATOR  = RATE_SCALE * WINDOW;
    localparam int NUM_W      = $clog2(NUMERATOR + 1);
    localparam int STEP_W     = $clog2(NUM_W);

    localparam logic [NUM_W-1:0]  NUM_BITS      = NUM_W'(NUMERATOR);
    localparam logic [SLOT_W-1:0] LAST_SLOT     = SLOT_W'(WINDOW - 1);
    localparam logic [SEEN_W-1:0] HALF_SEEN     = SEEN_W'(HALF_WINDOW);
    localparam logic [RATE_W-1:0] RATE_MAX_CODE = RATE_W'(RATE_MAX);
    localparam logic [STEP_W-1:0] FIRST_STEP    = STEP_W'(NUM_W - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic warm_next;
        logic div_last;
    } sts_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

### design/wfrm_stamp_if.sv
interface wfrm_stamp_if;
    logic                          valid;
    logic                          ready;
    logic [wfrm_pkg::STAMP_W-1:0]  timestamp_ms;

    modport source (output valid, output timestamp_ms, input ready);
    modport sink   (input valid, input timestamp_ms, output ready);
endinterface

### design/wfrm_rate_if.sv
interface wfrm_rate_if;
    logic                         valid;
    logic                         ready;
    logic [wfrm_pkg::RATE_W-1:0]  frame_rate;
    logic                         warmed_up;

    modport source (output valid, output frame_rate, output warmed_up, input ready);
    modport sink   (input valid, input frame_rate, input warmed_up, output ready);
endinterface

### design/windowed_frame_rate_meter_unit.sv
// Channel  Direction  Word contents
// -------  ---------  ----------------------------------------------------
// stamp    in         timestamp_ms [31:0], one word per displayed frame
// rate     out        frame_rate [13:0], warmed_up, one word per stamp word
//
// Before warm-up the division is skipped: the stamp word is captured, the ring
// is updated and the result is registered. Once warmed up, the restoring divider
// works out 32000 / window sum one quotient bit per cycle between the ring
// update and the result. The next stamp word is taken only once the block is
// idle again after the result is registered, so the block cannot take a new
// stamp word before it is through with the last one.
// Reset is asynchronous and active low; the ring is seen as all zero through
// per-entry valid bits, so there is no clearing pass.
// A stalled result waits in the output register; a new stamp word is taken
// while it waits, and the next result is held back until that slot is free.
module windowed_frame_rate_meter_unit (
    input  logic         clk,
    input  logic         rst_n,
    wfrm_stamp_if.sink   stamp,
    wfrm_rate_if.source  rate
);

    wfrm_pkg::cmd_t cmd;
    wfrm_pkg::sts_t sts;

    // The controller sequences capture, ring update, division and hand-off.
    wfrm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stamp.valid),
        .in_ready  (stamp.ready),
        .out_valid (rate.valid),
        .out_ready (rate.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the ring, the running sum, the divider and the result.
    wfrm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .timestamp_ms (stamp.timestamp_ms),
        .frame_rate   (rate.frame_rate),
        .warmed_up    (rate.warmed_up)
    );

endmodule

### design/wfrm_ctrl.sv
module wfrm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  wfrm_pkg::sts_t   sts,
    output wfrm_pkg::cmd_t   cmd
);

    wfrm_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == wfrm_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            wfrm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = wfrm_pkg::ST_UPDATE;
                end
            end
            wfrm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = sts.warm_next ? wfrm_pkg::ST_DIV : wfrm_pkg::ST_FINISH;
            end
            wfrm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = wfrm_pkg::ST_FINISH;
                end
            end
            wfrm_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = wfrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wfrm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wfrm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/wfrm_datapath.sv
module wfrm_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wfrm_pkg::cmd_t                cmd,
    output wfrm_pkg::sts_t                sts,
    input  logic [wfrm_pkg::STAMP_W-1:0]  timestamp_ms,
    output logic [wfrm_pkg::RATE_W-1:0]   frame_rate,
    output logic                          warmed_up
);

    // Frame-time ring; the valid bits stand in for the cleared reset contents.
    logic [wfrm_pkg::STAMP_W-1:0] ring_mem [wfrm_pkg::WINDOW];
    logic [wfrm_pkg::WINDOW-1:0]  ring_valid_reg;

    logic [wfrm_pkg::STAMP_W-1:0] stamp_reg;
    logic [wfrm_pkg::STAMP_W-1:0] last_reg;
    logic [wfrm_pkg::STAMP_W-1:0] old_reg;
    logic                         old_valid_reg;
    logic [wfrm_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [wfrm_pkg::SEEN_W-1:0]  seen_reg, seen_next;
    logic [wfrm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [wfrm_pkg::SUM_W-1:0]   divisor_reg;
    logic [wfrm_pkg::SUM_W-1:0]   rem_reg, rem_next;
    logic [wfrm_pkg::NUM_W-1:0]   quo_reg;
    logic [wfrm_pkg::STEP_W-1:0]  step_reg;
    logic [wfrm_pkg::RATE_W-1:0]  held_reg, held_next;
    logic [wfrm_pkg::RATE_W-1:0]  rate_reg;
    logic                         warm_reg;

    logic [wfrm_pkg::STAMP_W-1:0] delta;
    logic [wfrm_pkg::STAMP_W-1:0] old_time;
    logic [wfrm_pkg::SUM_W:0]     trial;
    logic                         fits;
    logic                         warm_now;

    assign delta    = stamp_reg - last_reg;
    assign old_time = old_valid_reg ? old_reg : '0;
    assign sum_next = sum_reg - wfrm_pkg::SUM_W'(old_time) + wfrm_pkg::SUM_W'(delta);
    assign slot_next = (slot_reg == wfrm_pkg::LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign seen_next = (seen_reg <= wfrm_pkg::HALF_SEEN) ? seen_reg + 1'b1 : seen_reg;

    // One restoring step: bring down the next numerator bit, subtract if it fits.
    assign trial    = {rem_reg, wfrm_pkg::NUM_BITS[step_reg]};
    assign fits     = (trial >= {1'b0, divisor_reg});
    assign rem_next = fits ? wfrm_pkg::SUM_W'(trial - {1'b0, divisor_reg})
                           : wfrm_pkg::SUM_W'(trial);

    assign warm_now = (seen_reg > wfrm_pkg::HALF_SEEN);

    always_comb
    begin
        if (!warm_now)
        begin
            held_next = held_reg;
        end
        else if (quo_reg > wfrm_pkg::NUM_W'(wfrm_pkg::RATE_MAX))
        begin
            held_next = wfrm_pkg::RATE_MAX_CODE;
        end
        else
        begin
            held_next = wfrm_pkg::RATE_W'(quo_reg);
        end
    end

    assign sts.warm_next = (seen_reg >= wfrm_pkg::HALF_SEEN);
    assign sts.div_last  = (step_reg == '0);

    assign frame_rate = rate_reg;
    assign warmed_up  = warm_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            old_reg <= ring_mem[slot_reg];
        end
        if (cmd.update)
        begin
            ring_mem[slot_reg] <= delta;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stamp_reg     <= timestamp_ms;
            old_valid_reg <= ring_valid_reg[slot_reg];
        end
        if (cmd.update)
        begin
            divisor_reg <= (sum_next == '0) ? wfrm_pkg::SUM_W'(1) : sum_next;
            rem_reg     <= '0;
            quo_reg     <= '0;
            step_reg    <= wfrm_pkg::FIRST_STEP;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[wfrm_pkg::NUM_W-2:0], fits};
            step_reg <= step_reg - 1'b1;
        end
        if (cmd.finish)
        begin
            rate_reg <= held_next;
            warm_reg <= warm_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
            last_reg       <= '0;
            slot_reg       <= '0;
            seen_reg       <= '0;
            sum_reg        <= '0;
            held_reg       <= '0;
        end
        else
        begin
            if (cmd.update)
            begin
                ring_valid_reg[slot_reg] <= 1'b1;
                last_reg                 <= stamp_reg;
                slot_reg                 <= slot_next;
                seen_reg                 <= seen_next;
                sum_reg                  <= sum_next;
            end
            if (cmd.finish)
            begin
                held_reg <= held_next;
            end
        end
    end

endmodule
